FILE: src/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg: shared constants and constant tables for the Legendre table block
// Root factors and diagonal normalisation roots, built at elaboration.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int MAX_DEGREES_DEF = 10;
	localparam int DEG_LIMIT       = 10;

	localparam logic [3:0] DEGREE_COUNT_RST = 4'd8;

	localparam int Q_W    = 16;
	localparam int ROOT_W = 18;
	localparam int DIAG_W = 15;
	localparam int ROOT_N = (DEG_LIMIT - 1) * (DEG_LIMIT - 1) + 1;
	localparam int ROOT_IW = $clog2(ROOT_N);

	localparam logic signed [Q_W-1:0] Q_ONE = 16'sd16384;

	typedef logic [ROOT_W-1:0] root_tab_t [ROOT_N];
	typedef logic [DIAG_W-1:0] diag_tab_t [DEG_LIMIT];

	function automatic logic [63:0] isqrt_c(input logic [63:0] x);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = x;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// floor(sqrt(x)) in Q14 for small integers x
	function automatic root_tab_t build_root_tab();
		root_tab_t t;
		logic [63:0] r;
		for (int i = 0; i < ROOT_N; i++) begin
			r = isqrt_c(64'(i) << 28);
			t[i] = r[ROOT_W-1:0];
		end
		return t;
	endfunction

	// root of the running product of (2m-1)/(2m), Q28 product, Q14 root
	function automatic diag_tab_t build_diag_tab();
		diag_tab_t t;
		logic [63:0] p;
		logic [63:0] r;
		p = 64'd1 << 28;
		r = isqrt_c(p);
		t[0] = r[DIAG_W-1:0];
		for (int m = 1; m < DEG_LIMIT; m++) begin
			p = p * 64'(2 * m - 1) / 64'(2 * m);
			r = isqrt_c(p);
			t[m] = r[DIAG_W-1:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOT_TAB = build_root_tab();
	localparam diag_tab_t DIAG_TAB = build_diag_tab();

endpackage

FILE: src/schmidt_legendre_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schmidt_legendre_table: semi-normalised associated Legendre table
// One cosine word in, the lower triangle Q[k][m] out, order by order.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_        in         cosine_in
// m_        out        degree, order, value, last (tlast)
// cfg_      in         degree_count
//
// The run time of one word for D degrees is set by the 21-step divider of the
// recurrence.
// The square root of 1 - mu^2 is found bit by bit before the first order.
// s_tready is high only between tables; a stalled output holds the sequencer.
// Reset clears the sequencer and output valid, and sets D to 8.
module schmidt_legendre_table #(
	parameter int MAX_DEGREES = slt_pkg::MAX_DEGREES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // cosine_in[15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // degree[3:0], order[7:4], value[23:8]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // degree_count
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SQ   = 5'd1;
	localparam logic [4:0] S_RI   = 5'd2;
	localparam logic [4:0] S_RT   = 5'd3;
	localparam logic [4:0] S_DIAG = 5'd4;
	localparam logic [4:0] S_PW   = 5'd5;
	localparam logic [4:0] S_DG   = 5'd6;
	localparam logic [4:0] S_DG2  = 5'd7;
	localparam logic [4:0] S_T1   = 5'd8;
	localparam logic [4:0] S_T2   = 5'd9;
	localparam logic [4:0] S_T3   = 5'd10;
	localparam logic [4:0] S_T4   = 5'd11;
	localparam logic [4:0] S_R1   = 5'd12;
	localparam logic [4:0] S_R2   = 5'd13;
	localparam logic [4:0] S_R3   = 5'd14;
	localparam logic [4:0] S_R4   = 5'd15;
	localparam logic [4:0] S_DIV  = 5'd16;
	localparam logic [4:0] S_R5   = 5'd17;
	localparam logic [4:0] S_EMIT = 5'd18;

	localparam int RW = slt_pkg::ROOT_W;
	localparam int IW = slt_pkg::ROOT_IW;
	localparam int QUOT_W = 21;
	localparam int DIV_W = 38;
	localparam logic signed [40:0] REM_ONE = 41'sd268435456;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       m_tvalid_q;
	logic [3:0] deg_cnt_q;

	logic signed [15:0] mu_q;
	logic [3:0]         d_q;
	logic [3:0]         m_q;
	logic [3:0]         k_q;
	logic signed [40:0] prod_q;
	logic signed [40:0] num_q;
	logic [28:0]        sq_v_q;
	logic [29:0]        sq_r_q;
	logic [4:0]         cnt_q;
	logic [14:0]        s_q;
	logic [14:0]        pw_q;
	logic signed [18:0] t_q;
	logic signed [15:0] q1_q;
	logic signed [15:0] q2_q;
	logic signed [15:0] res_q;
	logic               neg_q;
	logic [DIV_W-1:0]   div_rem_q;
	logic [RW-1:0]      rb_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [3:0]         out_k_q;
	logic [3:0]         out_m_q;
	logic signed [15:0] out_v_q;
	logic               out_last_q;

	function automatic logic signed [40:0] rnd14(input logic signed [40:0] v);
		logic [40:0] mag;
		logic [40:0] r;
		mag = v[40] ? unsigned'(-v) : unsigned'(v);
		r = (mag + 41'd8192) >> 14;
		return v[40] ? -signed'(r) : signed'(r);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
		if (v > 41'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -41'sd32768) begin
			return -16'sh8000;
		end
		return v[15:0];
	endfunction

	// clamped degree count
	logic [3:0] d_eff;
	always_comb begin
		if (deg_cnt_q == 4'd0) begin
			d_eff = 4'd1;
		end else if (deg_cnt_q > 4'(MAX_DEGREES)) begin
			d_eff = 4'(MAX_DEGREES);
		end else begin
			d_eff = deg_cnt_q;
		end
	end

	// root table indices
	logic [3:0]    km1;
	logic [7:0]    kk;
	logic [7:0]    k1k1;
	logic [7:0]    mm;
	logic [IW-1:0] odd_idx;
	logic [IW-1:0] ra_idx;
	logic [IW-1:0] rb_idx;
	logic [RW-1:0] rb;
	assign km1 = k_q - 4'd1;
	assign kk = {4'd0, k_q} * {4'd0, k_q};
	assign k1k1 = {4'd0, km1} * {4'd0, km1};
	assign mm = {4'd0, m_q} * {4'd0, m_q};
	assign odd_idx = IW'({m_q, 1'b1});
	assign ra_idx = IW'(k1k1 - mm);
	assign rb_idx = IW'(kk - mm);
	assign rb = slt_pkg::ROOT_TAB[rb_idx];

	// shared multiplier
	logic signed [21:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [40:0] mul_p;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = 22'(mu_q);
				mul_b = 19'(mu_q);
			end
			S_DIAG: begin
				mul_a = {7'd0, pw_q};
				mul_b = {4'd0, s_q};
			end
			S_DG: begin
				mul_a = {7'd0, slt_pkg::DIAG_TAB[m_q]};
				mul_b = {4'd0, pw_q};
			end
			S_T1: begin
				mul_a = {4'd0, slt_pkg::ROOT_TAB[odd_idx]};
				mul_b = 19'(mu_q);
			end
			S_T3: begin
				mul_a = 22'(t_q);
				mul_b = 19'(q2_q);
			end
			S_R1: begin
				mul_a = {17'd0, k_q, 1'b0} - 22'sd1;
				mul_b = 19'(mu_q);
			end
			S_R2: begin
				mul_a = prod_q[21:0];
				mul_b = 19'(q1_q);
			end
			S_R3: begin
				mul_a = {4'd0, slt_pkg::ROOT_TAB[ra_idx]};
				mul_b = 19'(q2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = 41'(mul_a) * 41'(mul_b);

	logic signed [40:0] rnd_p;
	logic signed [15:0] sat_p;
	assign rnd_p = rnd14(prod_q);
	assign sat_p = sat16(rnd_p);

	// root of 1 - mu^2
	logic signed [40:0] rem_full;
	logic [29:0]        sq_bit;
	logic [29:0]        sq_sum;
	logic               sq_take;
	logic [29:0]        sq_r_nx;
	assign rem_full = REM_ONE - prod_q;
	assign sq_bit = 30'd1 << {cnt_q, 1'b0};
	assign sq_sum = sq_r_q + sq_bit;
	assign sq_take = {1'b0, sq_v_q} >= sq_sum;
	assign sq_r_nx = sq_take ? (sq_r_q >> 1) + sq_bit : sq_r_q >> 1;

	// recurrence division
	logic signed [40:0] diff;
	logic [40:0]        diff_mag;
	logic [DIV_W-1:0]   rb_sh;
	logic [DIV_W:0]     trial;
	logic signed [40:0] quot_s;
	logic signed [15:0] sat_div;
	assign diff = num_q - prod_q;
	assign diff_mag = diff[40] ? unsigned'(-diff) : unsigned'(diff);
	assign rb_sh = DIV_W'(rb_q) << cnt_q;
	assign trial = {1'b0, div_rem_q} - {1'b0, rb_sh};
	assign quot_s = neg_q ? -signed'(41'(quot_q)) : signed'(41'(quot_q));
	assign sat_div = sat16(quot_s);

	logic out_free;
	logic col_end;
	logic tab_end;
	assign out_free = !m_tvalid_q || m_tready;
	assign col_end = k_q == d_q - 4'd1;
	assign tab_end = col_end && (m_q == d_q - 4'd1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_SQ;
			end
			S_SQ:   state_d = S_RI;
			S_RI:   state_d = S_RT;
			S_RT: begin
				if (cnt_q == 5'd0) state_d = S_DIAG;
			end
			S_DIAG: state_d = (m_q == 4'd0) ? S_EMIT : S_PW;
			S_PW:   state_d = S_DG;
			S_DG:   state_d = S_DG2;
			S_DG2:  state_d = S_EMIT;
			S_T1:   state_d = S_T2;
			S_T2:   state_d = S_T3;
			S_T3:   state_d = S_T4;
			S_T4:   state_d = S_EMIT;
			S_R1:   state_d = S_R2;
			S_R2:   state_d = S_R3;
			S_R3:   state_d = S_R4;
			S_R4:   state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == 5'd0) state_d = S_R5;
			end
			S_R5:   state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					priority if (tab_end) begin
						state_d = S_IDLE;
					end else if (col_end) begin
						state_d = S_DIAG;
					end else if (k_q == m_q) begin
						state_d = S_T1;
					end else begin
						state_d = S_R1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_tvalid_q <= 1'b0;
			deg_cnt_q <= slt_pkg::DEGREE_COUNT_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid) deg_cnt_q <= cfg_data;
			m_tvalid_q <= (state_q == S_EMIT && out_free) || (m_tvalid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					mu_q <= s_tdata;
					d_q <= d_eff;
					m_q <= 4'd0;
					k_q <= 4'd0;
				end
			end
			S_SQ: prod_q <= mul_p;
			S_RI: begin
				sq_v_q <= rem_full[40] ? 29'd0 : rem_full[28:0];
				sq_r_q <= '0;
				cnt_q <= 5'd14;
			end
			S_RT: begin
				if (sq_take) sq_v_q <= sq_v_q - sq_sum[28:0];
				sq_r_q <= sq_r_nx;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					s_q <= sq_r_nx[14:0];
					pw_q <= 15'd16384;
				end
			end
			S_DIAG: begin
				if (m_q == 4'd0) begin
					q2_q <= slt_pkg::Q_ONE;
					res_q <= slt_pkg::Q_ONE;
				end else begin
					prod_q <= mul_p;
				end
			end
			S_PW: pw_q <= rnd_p[14:0];
			S_DG: prod_q <= mul_p;
			S_DG2: begin
				q2_q <= sat_p;
				res_q <= sat_p;
			end
			S_T1: prod_q <= mul_p;
			S_T2: t_q <= rnd_p[18:0];
			S_T3: prod_q <= mul_p;
			S_T4: begin
				q1_q <= sat_p;
				res_q <= sat_p;
			end
			S_R1: prod_q <= mul_p;
			S_R2: prod_q <= mul_p;
			S_R3: begin
				num_q <= prod_q;
				prod_q <= mul_p;
			end
			S_R4: begin
				neg_q <= diff[40];
				div_rem_q <= DIV_W'(diff_mag) + DIV_W'(rb >> 1);
				rb_q <= rb;
				quot_q <= '0;
				cnt_q <= 5'(QUOT_W - 1);
			end
			S_DIV: begin
				if (!trial[DIV_W]) begin
					div_rem_q <= trial[DIV_W-1:0];
					quot_q[cnt_q] <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
			S_R5: begin
				q2_q <= q1_q;
				q1_q <= sat_div;
				res_q <= sat_div;
			end
			S_EMIT: begin
				if (out_free) begin
					out_k_q <= k_q;
					out_m_q <= m_q;
					out_v_q <= res_q;
					out_last_q <= tab_end;
					if (col_end) begin
						m_q <= m_q + 4'd1;
						k_q <= m_q + 4'd1;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {out_v_q, out_m_q, out_k_q};
	assign m_tlast = out_last_q;

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[3:0] == m_tdata[7:4])
		else $error("final word of a table is not on the diagonal");

	a_lower: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:4] <= m_tdata[3:0])
		else $error("order above degree");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after a word was taken");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && out_free |=> m_tvalid)
		else $error("emitted word not presented");

endmodule

FILE: verif/tb_schmidt_legendre_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_schmidt_legendre_table: self-checking bench for the Legendre table block
// Sends cosine words under several degree counts and predicts each table word
// in integer arithmetic. The output stream is checked word by word, with random
// input gaps, random output back-pressure and one long output stall.
// ----------------------------------------------------------------------------
module tb_schmidt_legendre_table;

	localparam int     WATCHDOG_LIMIT = 30000;
	localparam int     LONG_HOLD      = 1500;
	localparam longint Q28_ONE        = 64'sd1 <<< 28;

	typedef struct packed {
		logic [3:0]         degree;
		logic [3:0]         order;
		logic signed [15:0] value;
		logic               last;
	} legendre_word_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = 16'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data  = 4'd0;

	logic [3:0]     active_degree_count = slt_pkg::DEGREE_COUNT_RST;
	legendre_word_t table_q[$];
	legendre_word_t want_word;
	int             fail_count   = 0;
	int             quiet_cycles = 0;
	int             rx_hold_req  = 0;
	bit             tx_burst     = 1'b0;
	bit             rx_burst     = 1'b0;

	schmidt_legendre_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned c;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= x)
				r = c;
		end
		return r;
	endfunction

	function automatic longint root_q14(input longint x);
		return longint'(floor_sqrt(x << 28));
	endfunction

	function automatic longint shift_round(input longint v, input int sh);
		longint half;
		half = 64'sd1 <<< (sh - 1);
		if (v >= 0)
			return (v + half) >>> sh;
		return -((-v + half) >>> sh);
	endfunction

	function automatic longint div_round(input longint num, input longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint clip_q14(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic void queue_word(input int k, input int m, input longint v,
			input bit lst);
		legendre_word_t w;
		w.degree = 4'(k);
		w.order  = 4'(m);
		w.value  = 16'(v);
		w.last   = lst;
		table_q.insert(table_q.size(), w);
	endfunction

	// expected table for one cosine word, order by order
	function automatic void predict_table(input logic [15:0] cos_word);
		int     d;
		int     n_words;
		int     idx;
		longint mu, rem, s, pw, prod, rp, q2, q1, t, ra, rb, num, v;
		d = active_degree_count;
		if (d < 1)
			d = 1;
		if (d > slt_pkg::MAX_DEGREES_DEF)
			d = slt_pkg::MAX_DEGREES_DEF;
		n_words = d * (d + 1) / 2;
		idx = 0;
		mu = longint'($signed(cos_word));
		rem = Q28_ONE - mu * mu;
		if (rem < 0)
			rem = 0;
		s = longint'(floor_sqrt(rem));
		pw = longint'(slt_pkg::Q_ONE);
		prod = Q28_ONE;
		for (int m = 0; m < d; m++) begin
			if (m == 0) begin
				q2 = longint'(slt_pkg::Q_ONE);
			end else begin
				pw = shift_round(pw * s, 14);
				prod = prod * (2 * m - 1) / (2 * m);
				rp = longint'(floor_sqrt(prod));
				q2 = clip_q14(shift_round(rp * pw, 14));
			end
			idx++;
			queue_word(m, m, q2, idx == n_words);
			if (m + 1 >= d)
				continue;
			t = shift_round(root_q14(2 * m + 1) * mu, 14);
			q1 = clip_q14(shift_round(t * q2, 14));
			idx++;
			queue_word(m + 1, m, q1, idx == n_words);
			for (int k = m + 2; k < d; k++) begin
				ra = root_q14((k - 1) * (k - 1) - m * m);
				rb = root_q14(k * k - m * m);
				num = (2 * k - 1) * mu * q1 - ra * q2;
				v = clip_q14(div_round(num, rb));
				idx++;
				queue_word(k, m, v, idx == n_words);
				q2 = q1;
				q1 = v;
			end
		end
	endfunction

	function automatic logic [15:0] random_cosine();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 16'($urandom_range(0, 32768) - 16384);
		if (r == 6)
			return ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
		return 16'($urandom);
	endfunction

	function automatic int tx_gap();
		int r;
		if (tx_burst)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_cosine(input logic [15:0] cos_word);
		int gap;
		gap = tx_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 16'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cos_word;
		do @(posedge clk); while (!s_tready);
		predict_table(cos_word);
	endtask

	task automatic wait_tables_done();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (table_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_degree_count(input logic [3:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		active_degree_count = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data  <= 4'($urandom);
	endtask

	task automatic test_reset_degree_count();
		send_cosine(16'h0000);
		send_cosine(16'h2000);
		wait_tables_done();
	endtask

	task automatic test_corner_cosines();
		logic [15:0] corner [12] = '{16'h4000, 16'hC000, 16'h0000, 16'h0001,
			16'hFFFF, 16'h7FFF, 16'h8000, 16'h4001, 16'hBFFF, 16'h2D41,
			16'h5555, 16'hAAAA};
		write_degree_count(4'd10);
		foreach (corner[i])
			send_cosine(corner[i]);
		wait_tables_done();
	endtask

	task automatic test_degree_clamp();
		write_degree_count(4'd0);
		send_cosine(random_cosine());
		send_cosine(16'h4000);
		wait_tables_done();
		write_degree_count(4'd15);
		send_cosine(random_cosine());
		wait_tables_done();
		write_degree_count(4'd11);
		send_cosine(16'hE000);
		wait_tables_done();
	endtask

	task automatic test_random_tables();
		int r;
		for (int phase = 0; phase < 10; phase++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				write_degree_count(4'($urandom_range(10, 15)));
			else if (r == 1)
				write_degree_count(4'($urandom_range(0, 1)));
			else
				write_degree_count(4'($urandom_range(2, 7)));
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			repeat (14)
				send_cosine(random_cosine());
			wait_tables_done();
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	// receiver holds off while words keep coming, so the input backs up
	task automatic test_output_stall();
		write_degree_count(4'd5);
		tx_burst = 1'b1;
		rx_hold_req = LONG_HOLD;
		repeat (12)
			send_cosine(random_cosine());
		tx_burst = 1'b0;
		wait_tables_done();
	endtask

	initial begin : rx_side
		int r;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_req) @(negedge clk);
				rx_hold_req = 0;
				m_tready <= 1'b1;
			end else if (rx_burst) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 19);
				if (r < 11) begin
					m_tready <= 1'b1;
				end else if (r < 18) begin
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b0;
					repeat ($urandom_range(8, 50)) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (table_q.size() == 0) begin
				$error("unexpected word: degree %0d order %0d value %0d", m_tdata[3:0],
					m_tdata[7:4], $signed(m_tdata[23:8]));
				fail_count++;
			end else begin
				want_word = table_q.pop_front();
				if (m_tdata[3:0] !== want_word.degree) begin
					$error("degree: expected %0d, got %0d", want_word.degree, m_tdata[3:0]);
					fail_count++;
				end
				if (m_tdata[7:4] !== want_word.order) begin
					$error("order: expected %0d, got %0d", want_word.order, m_tdata[7:4]);
					fail_count++;
				end
				if (m_tdata[23:8] !== want_word.value) begin
					$error("value: expected %0d, got %0d", want_word.value,
						$signed(m_tdata[23:8]));
					fail_count++;
				end
				if (m_tlast !== want_word.last) begin
					$error("last: expected %0d, got %0d", want_word.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[schmidt_legendre_table] ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_degree_count();
		test_corner_cosines();
		test_degree_clamp();
		test_random_tables();
		test_output_stall();
		wait_tables_done();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("[schmidt_legendre_table] OK");
		end else begin
			$display("[schmidt_legendre_table] ERROR");
		end
		$finish;
	end

endmodule

FILE: schmidt_legendre_table.f
src/slt_pkg.sv
src/schmidt_legendre_table.sv
verif/tb_schmidt_legendre_table.sv
